>>> hw/rtl/sacs_pkg.sv
package sacs_pkg;

    localparam int ROWS     = 4;
    localparam int COLUMNS  = 1024;
    localparam int IN_ROWS  = 4;
    localparam int COL_IN_W = 10;
    localparam int RND_W    = 7;
    localparam int CNT_W    = 8;
    localparam int EXP_W    = 3;
    localparam int MANT_W   = 5;
    localparam int EST_W    = 13;
    localparam int TOT_W    = 32;
    localparam int DEPTH    = ROWS * COLUMNS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [EST_W-1:0]  EST_INIT = '1;
    localparam logic [MANT_W-1:0] MANT_MAX = '1;
    localparam logic [EXP_W-1:0]  EXP_MAX  = '1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CNT_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // restoring reduction of a column index modulo COLUMNS
    function automatic logic [COL_IN_W-1:0] col_reduce(input logic [COL_IN_W-1:0] col);
        logic [COL_IN_W-1:0] v;
        v = col;
        for (int k = COL_IN_W - 1; k >= 0; k--) begin
            if (int'(v) >= (COLUMNS << k)) begin
                v = v - COL_IN_W'(COLUMNS << k);
            end
        end
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input int row,
                                                    input logic [COL_IN_W-1:0] col);
        return ADDR_W'(row * COLUMNS) + ADDR_W'(col_reduce(col));
    endfunction

endpackage

>>> hw/rtl/self_adaptive_counter_sketch_top.sv
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+-------------------------------------
// command  | in        | start & !busy at clock edge  | i_kind, i_col_row0..3, i_rnd_row0..3
// result   | out       | o_valid, one cycle, no stall | o_estimate, o_insert_total
//
// Per item, the accept cycle reads row 0, then each row in turn passes through the counter
// arithmetic unit with one read and, for an insert only, one write on the counter memory.
// The result strobe comes with busy low after the last row; a new transaction may start then.
// After reset all ROWS*COLUMNS = 4096 memory entries are cleared, one entry per cycle,
// with busy high. Reset is synchronous, active low. The receiver cannot stall.
module self_adaptive_counter_sketch_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_kind,
    input  logic [sacs_pkg::COL_IN_W-1:0]  i_col_row0,
    input  logic [sacs_pkg::COL_IN_W-1:0]  i_col_row1,
    input  logic [sacs_pkg::COL_IN_W-1:0]  i_col_row2,
    input  logic [sacs_pkg::COL_IN_W-1:0]  i_col_row3,
    input  logic [sacs_pkg::RND_W-1:0]     i_rnd_row0,
    input  logic [sacs_pkg::RND_W-1:0]     i_rnd_row1,
    input  logic [sacs_pkg::RND_W-1:0]     i_rnd_row2,
    input  logic [sacs_pkg::RND_W-1:0]     i_rnd_row3,
    output logic                           o_valid,
    output logic [sacs_pkg::EST_W-1:0]     o_estimate,
    output logic [sacs_pkg::TOT_W-1:0]     o_insert_total
);
    import sacs_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_RUN   = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_kind, n_kind;
    logic [ADDR_W-1:0] r_addrq [ROWS+1];
    logic [ADDR_W-1:0] n_addrq [ROWS+1];
    logic [RND_W-1:0]  r_rndq  [ROWS+1];
    logic [RND_W-1:0]  n_rndq  [ROWS+1];
    logic [EST_W-1:0]  r_est, n_est;
    logic [TOT_W-1:0]  r_ins_cnt, n_ins_cnt;
    logic              r_valid, n_valid;
    logic [EST_W-1:0]  r_o_est, n_o_est;
    logic [TOT_W-1:0]  r_o_tot, n_o_tot;

    logic [COL_IN_W-1:0] w_col_in [IN_ROWS];
    logic [RND_W-1:0]    w_rnd_in [IN_ROWS];
    logic [ADDR_W-1:0]   w_ld_addr [ROWS+1];
    logic [RND_W-1:0]    w_ld_rnd  [ROWS+1];
    logic [EST_W-1:0]    w_min;
    logic                w_accept;

    t_mem_req          w_req;
    logic [CNT_W-1:0]  w_rdata;
    logic [CNT_W-1:0]  w_bumped;
    logic [EST_W-1:0]  w_decoded;

    assign w_col_in[0] = i_col_row0;
    assign w_col_in[1] = i_col_row1;
    assign w_col_in[2] = i_col_row2;
    assign w_col_in[3] = i_col_row3;
    assign w_rnd_in[0] = i_rnd_row0;
    assign w_rnd_in[1] = i_rnd_row1;
    assign w_rnd_in[2] = i_rnd_row2;
    assign w_rnd_in[3] = i_rnd_row3;

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            w_ld_addr[r] = slot_addr(r, w_col_in[r]);
            w_ld_rnd[r]  = w_rnd_in[r];
        end
        w_ld_addr[ROWS] = '0;
        w_ld_rnd[ROWS]  = '0;
    end

    sacs_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    sacs_unit u_unit (
        .i_cnt     (w_rdata),
        .i_rnd     (r_rndq[0]),
        .o_bumped  (w_bumped),
        .o_decoded (w_decoded)
    );

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && (r_state == ST_IDLE);
    assign w_min    = (w_decoded < r_est) ? w_decoded : r_est;

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_clr     = r_clr;
        n_kind    = r_kind;
        n_addrq   = r_addrq;
        n_rndq    = r_rndq;
        n_est     = r_est;
        n_ins_cnt = r_ins_cnt;
        n_valid   = 1'b0;
        n_o_est   = r_o_est;
        n_o_tot   = r_o_tot;
        w_req     = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_clr;
                n_clr       = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // issue the row 0 read ahead of the accept edge
                w_req.raddr = w_ld_addr[0];
                if (w_accept) begin
                    n_state = ST_RUN;
                    n_row   = '0;
                    n_kind  = i_kind;
                    n_addrq = w_ld_addr;
                    n_rndq  = w_ld_rnd;
                    n_est   = EST_INIT;
                    if (!i_kind) begin
                        n_ins_cnt = r_ins_cnt + TOT_W'(1);
                    end
                end
            end
            ST_RUN: begin
                w_req.raddr = r_addrq[1];
                w_req.waddr = r_addrq[0];
                w_req.wdata = w_bumped;
                w_req.we    = !r_kind;
                for (int q = 0; q < ROWS; q++) begin
                    n_addrq[q] = r_addrq[q+1];
                    n_rndq[q]  = r_rndq[q+1];
                end
                n_addrq[ROWS] = '0;
                n_rndq[ROWS]  = '0;
                n_est         = w_min;
                if (r_row == ROW_W'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                    n_o_est = r_kind ? w_min : '0;
                    n_o_tot = r_ins_cnt;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_row     <= '0;
            r_clr     <= '0;
            r_ins_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_clr     <= n_clr;
            r_ins_cnt <= n_ins_cnt;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_addrq <= n_addrq;
        r_rndq  <= n_rndq;
        r_est   <= n_est;
        r_o_est <= n_o_est;
        r_o_tot <= n_o_tot;
    end

    assign o_valid        = r_valid;
    assign o_estimate     = r_o_est;
    assign o_insert_total = r_o_tot;

endmodule

>>> hw/rtl/sacs_unit.sv
module sacs_unit (
    input  logic [sacs_pkg::CNT_W-1:0] i_cnt,
    input  logic [sacs_pkg::RND_W-1:0] i_rnd,
    output logic [sacs_pkg::CNT_W-1:0] o_bumped,
    output logic [sacs_pkg::EST_W-1:0] o_decoded
);
    import sacs_pkg::*;

    logic [EXP_W-1:0]  w_exp;
    logic [MANT_W-1:0] w_mant;
    logic [RND_W-1:0]  w_mask;
    logic              w_skip;

    assign w_exp  = i_cnt[CNT_W-1:MANT_W];
    assign w_mant = i_cnt[MANT_W-1:0];
    // exponent at top makes the shift fall off, and the mask becomes all ones
    assign w_mask = (RND_W'(1) << w_exp) - RND_W'(1);
    assign w_skip = |(i_rnd & w_mask);

    always_comb begin
        priority if (w_skip) begin
            o_bumped = i_cnt;
        end else if (w_mant != MANT_MAX) begin
            o_bumped = i_cnt + CNT_W'(1);
        end else if (w_exp == EXP_MAX) begin
            o_bumped = i_cnt;   // saturate at the top value
        end else begin
            o_bumped = {w_exp + EXP_W'(1), {MANT_W{1'b0}}};
        end
    end

    // m*2^e + 32*(2^e - 1) == (m + 32)*2^e - 32
    assign o_decoded = (EST_W'({1'b1, w_mant}) << w_exp) - EST_W'(32);

endmodule

>>> hw/rtl/sacs_store.sv
module sacs_store (
    input  logic                        i_clk,
    input  sacs_pkg::t_mem_req          i_req,
    output logic [sacs_pkg::CNT_W-1:0]  o_rdata
);
    import sacs_pkg::*;

    logic [CNT_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

>>> hw/rtl/sacs_chk.sv
module sacs_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           i_kind,
    input logic                           o_valid,
    input logic [sacs_pkg::EST_W-1:0]     o_estimate
);
    import sacs_pkg::*;

    // busy must be high right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted transaction");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(ROWS + 1) o_valid)
        else $error("result strobe missing at fixed latency");

    a_insert_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_kind) |-> ##(ROWS + 1) (o_estimate == '0))
        else $error("insert result carries a nonzero estimate");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

endmodule

bind self_adaptive_counter_sketch_top sacs_chk u_sacs_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_kind     (i_kind),
    .o_valid    (o_valid),
    .o_estimate (o_estimate)
);
